>>> sv/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } t_out;

endpackage

>>> sv/lkvc_store.sv
// entry store: parallel tag match, free and victim select, recency rank update
module lkvc_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  lkvc_pkg::t_in          i_req,
    input  logic [lkvc_pkg::CAP_W-1:0] i_capacity,
    output lkvc_pkg::t_out         o_rsp
);
    import lkvc_pkg::*;

    logic [MAX_ENTRIES-1:0]  r_valid;
    logic [KEY_W-1:0]        r_key   [MAX_ENTRIES];
    logic [VAL_W-1:0]        r_value [MAX_ENTRIES];
    logic [RANK_W-1:0]       r_rank  [MAX_ENTRIES];
    logic [CNT_W-1:0]        r_used;

    logic [RANK_W-1:0]       n_rank  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  n_valid;
    logic [CNT_W-1:0]        n_used;

    logic [MAX_ENTRIES-1:0]  w_hit_vec;
    logic [MAX_ENTRIES-1:0]  w_free_vec;
    logic [MAX_ENTRIES-1:0]  w_victim_vec;
    logic [MAX_ENTRIES-1:0]  w_tgt_vec;
    logic                    w_hit;
    logic                    w_fill;
    logic                    w_touch;
    logic                    w_write;
    logic [RANK_W-1:0]       w_tgt_rank;
    logic [RANK_W-1:0]       w_oldest;
    logic [VAL_W-1:0]        w_hit_value;
    logic [31:0]             w_eff_cap;
    logic                    w_free_seen;

    always_comb begin
        w_eff_cap = 32'(i_capacity);
        if (w_eff_cap == 32'd0) begin
            w_eff_cap = 32'd1;
        end
        if (w_eff_cap > 32'(MAX_ENTRIES)) begin
            w_eff_cap = 32'(MAX_ENTRIES);
        end
    end

    // least recent valid entry holds rank used-1
    assign w_oldest = RANK_W'(r_used - CNT_W'(1));

    always_comb begin
        w_free_seen = 1'b0;
        w_hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit_vec[i]    = r_valid[i] && (r_key[i] == i_req.key);
            w_victim_vec[i] = r_valid[i] && (r_rank[i] == w_oldest);
            w_free_vec[i]   = !r_valid[i] && !w_free_seen;
            if (!r_valid[i]) begin
                w_free_seen = 1'b1;
            end
            if (w_hit_vec[i]) begin
                w_hit_value = w_hit_value | r_value[i];
            end
        end
    end

    assign w_hit   = |w_hit_vec;
    assign w_fill  = !w_hit && (i_req.operation == OP_SET) && w_free_seen
                     && (32'(r_used) < w_eff_cap);
    assign w_write = i_en && (i_req.operation == OP_SET);
    assign w_touch = i_en && (w_hit || (i_req.operation == OP_SET));
    assign w_tgt_vec = w_hit ? w_hit_vec : (w_fill ? w_free_vec : w_victim_vec);

    always_comb begin
        w_tgt_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_tgt_vec[i]) begin
                w_tgt_rank = w_tgt_rank | r_rank[i];
            end
        end
    end

    // target goes to rank 0, valid entries newer than it age by one (on a fill, every valid entry does)
    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (w_touch) begin
                if (w_tgt_vec[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (w_fill || (r_rank[i] < w_tgt_rank))) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
        if (w_write && w_fill) begin
            n_valid = r_valid | w_tgt_vec;
            n_used  = r_used + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else begin
            r_valid <= n_valid;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            r_rank[i] <= n_rank[i];
            if (w_write && w_tgt_vec[i]) begin
                r_value[i] <= i_req.value;
                if (!w_hit) begin
                    r_key[i] <= i_req.key;
                end
            end
        end
    end

    always_comb begin
        o_rsp.found      = w_hit;
        o_rsp.read_value = w_hit ? w_hit_value : MISS_VALUE;
    end

endmodule

>>> sv/lru_key_value_cache_unit.sv
// lru key-value cache top level: input register, entry store, result register
// a transfer in is captured in the input register, then looked up and applied in the
// store once it may go, and a get's result is captured in the result register and
// offered on o_valid; one item per cycle sustained while the output does not stall,
// with the tag match and rank update done combinationally across all entries
// synchronous active-low reset empties the cache and sets capacity to 16
module lru_key_value_cache_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  lkvc_pkg::t_in              i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output lkvc_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_data
);
    import lkvc_pkg::*;

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic [CAP_W-1:0]  r_capacity;

    t_out              w_rsp;
    logic              w_out_free;
    logic              w_go;
    logic              w_take;

    assign w_out_free = !r_out_valid || !i_stall;
    // a set makes no result, so it never waits on the output side
    assign w_go    = r_in_valid && ((r_in.operation == OP_SET) || w_out_free);
    assign o_stall = r_in_valid && !w_go;
    assign w_take  = i_valid && !o_stall;

    lkvc_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_go),
        .i_req      (r_in),
        .i_capacity (r_capacity),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go && (r_in.operation == OP_GET)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in;
        end
        if (w_go && (r_in.operation == OP_GET)) begin
            r_out <= w_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
